### design/gaq_pkg.sv
// shared types, register indexes, action codes and helpers for the action qualifier
`timescale 1ns / 1ps

package gaq_pkg;

    localparam int BUTTON_COUNT_DEF = 21;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_STICK_ENGAGE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STICK_RELEASE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_DELAY    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_INTERVAL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK_INDEX      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIRM_INDEX   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED         = 3'd6;

    localparam logic [15:0] RST_STICK_ENGAGE    = 16'd16384;
    localparam logic [15:0] RST_STICK_RELEASE   = 16'd8192;
    localparam logic [15:0] RST_REPEAT_DELAY    = 16'd400;
    localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd120;
    localparam logic [4:0]  RST_BACK_INDEX      = 5'd1;
    localparam logic [4:0]  RST_CONFIRM_INDEX   = 5'd0;

    localparam logic [3:0] ACT_UP        = 4'd0;
    localparam logic [3:0] ACT_DOWN      = 4'd1;
    localparam logic [3:0] ACT_LEFT      = 4'd2;
    localparam logic [3:0] ACT_RIGHT     = 4'd3;
    localparam logic [3:0] ACT_CONFIRM   = 4'd4;
    localparam logic [3:0] ACT_BACK      = 4'd5;
    localparam logic [3:0] ACT_MENU      = 4'd6;
    localparam logic [3:0] ACT_HOME      = 4'd7;
    localparam logic [3:0] ACT_PREVPAGE  = 4'd8;
    localparam logic [3:0] ACT_NEXTPAGE  = 4'd9;
    localparam logic [3:0] ACT_PREVFACE  = 4'd10;
    localparam logic [3:0] ACT_NEXTFACE  = 4'd11;
    localparam logic [3:0] ACT_LOCAL     = 4'd12;
    localparam logic [3:0] ACT_TOGGLE    = 4'd13;
    localparam logic [3:0] ACT_SECONDARY = 4'd14;

    localparam logic [2:0] DIR_UP    = 3'd0;
    localparam logic [2:0] DIR_DOWN  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_NONE  = 3'd7;

    // fixed button bits
    localparam logic [4:0] BTN_X         = 5'd2;
    localparam logic [4:0] BTN_Y         = 5'd3;
    localparam logic [4:0] BTN_BACK      = 5'd4;
    localparam logic [4:0] BTN_GUIDE     = 5'd5;
    localparam logic [4:0] BTN_START     = 5'd6;
    localparam logic [4:0] BTN_LSHOULDER = 5'd9;
    localparam logic [4:0] BTN_RSHOULDER = 5'd10;
    localparam logic [4:0] BTN_DPAD_UP   = 5'd11;
    localparam logic [4:0] BTN_DPAD_DOWN = 5'd12;
    localparam logic [4:0] BTN_DPAD_LEFT = 5'd13;
    localparam logic [4:0] BTN_DPAD_RIGHT = 5'd14;

    // fire mask positions in emission order: nine buttons, two triggers, direction
    localparam int FIRE_W  = 12;
    localparam int FIRE_PW = 4;
    localparam logic [FIRE_PW-1:0] POS_PREVPAGE  = 4'd0;
    localparam logic [FIRE_PW-1:0] POS_NEXTPAGE  = 4'd1;
    localparam logic [FIRE_PW-1:0] POS_MENU      = 4'd2;
    localparam logic [FIRE_PW-1:0] POS_HOME      = 4'd3;
    localparam logic [FIRE_PW-1:0] POS_LOCAL     = 4'd4;
    localparam logic [FIRE_PW-1:0] POS_BACK      = 4'd5;
    localparam logic [FIRE_PW-1:0] POS_TOGGLE    = 4'd6;
    localparam logic [FIRE_PW-1:0] POS_SECONDARY = 4'd7;
    localparam logic [FIRE_PW-1:0] POS_CONFIRM   = 4'd8;
    localparam logic [FIRE_PW-1:0] POS_PREVFACE  = 4'd9;
    localparam logic [FIRE_PW-1:0] POS_NEXTFACE  = 4'd10;
    localparam logic [FIRE_PW-1:0] POS_DIR       = 4'd11;

    typedef struct packed {
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic [14:0]        trigger_left;
        logic [14:0]        trigger_right;
        logic               attached;
        logic [31:0]        now_ms;
    } tick_t;

    typedef struct packed {
        logic [FIRE_W-1:0] fire;
        logic [1:0]        dir;
        logic              gate;
    } entry_t;

    function automatic logic [3:0] code_of(input logic [FIRE_PW-1:0] pos, input logic [1:0] dir);
        logic [3:0] code;
        unique case (pos)
            POS_PREVPAGE:  code = ACT_PREVPAGE;
            POS_NEXTPAGE:  code = ACT_NEXTPAGE;
            POS_MENU:      code = ACT_MENU;
            POS_HOME:      code = ACT_HOME;
            POS_LOCAL:     code = ACT_LOCAL;
            POS_BACK:      code = ACT_BACK;
            POS_TOGGLE:    code = ACT_TOGGLE;
            POS_SECONDARY: code = ACT_SECONDARY;
            POS_CONFIRM:   code = ACT_CONFIRM;
            POS_PREVFACE:  code = ACT_PREVFACE;
            POS_NEXTFACE:  code = ACT_NEXTFACE;
            default:       code = {2'b00, dir};
        endcase
        return code;
    endfunction

endpackage

### design/gaq_front.sv
// front end: configuration registers, tick state and classification into fire masks
`timescale 1ns / 1ps

module gaq_front
    import gaq_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    tick_accept,
    input  logic [BUTTON_COUNT-1:0] button_bits,
    input  tick_t                   tick,
    output logic                    push,
    output entry_t                  push_entry
);

    logic [15:0] stick_engage_reg;
    logic [15:0] stick_release_reg;
    logic [15:0] repeat_delay_reg;
    logic [15:0] repeat_interval_reg;
    logic [4:0]  back_index_reg;
    logic [4:0]  confirm_index_reg;
    logic        enabled_reg;

    logic [BUTTON_COUNT-1:0] prev_buttons_reg, prev_buttons_next;
    logic [1:0]              trig_pressed_reg, trig_pressed_next;
    logic [2:0]              held_dir_reg, held_dir_next;
    logic [31:0]             next_repeat_reg, next_repeat_next;
    logic                    gate_reg, gate_next;
    logic                    was_attached_reg, was_attached_next;

    logic [31:0]       cur_bits;
    logic [31:0]       old_bits;
    logic [16:0]       mag_x;
    logic [16:0]       mag_y;
    logic [16:0]       release_lvl;
    logic [16:0]       engage_lvl;
    logic [16:0]       dir_thr;
    logic              neutral;
    logic [FIRE_W-1:0] fire;
    logic [2:0]        cur_dir;
    logic [1:0]        trig_now;
    logic [31:0]       repeat_gap;

    function automatic logic bit_at(input logic [31:0] bits, input logic [4:0] idx);
        return (32'(idx) < 32'(BUTTON_COUNT)) ? bits[idx] : 1'b0;
    endfunction

    function automatic logic [16:0] magnitude(input logic signed [15:0] raw);
        logic [15:0] v;
        v = unsigned'(raw);
        return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    endfunction

    assign cur_bits    = 32'(button_bits);
    assign old_bits    = 32'(prev_buttons_reg);
    assign mag_x       = magnitude(tick.stick_x);
    assign mag_y       = magnitude(tick.stick_y);
    assign release_lvl = {1'b0, stick_release_reg};
    assign engage_lvl  = {1'b0, stick_engage_reg};
    assign dir_thr     = (held_dir_reg != DIR_NONE) ? release_lvl : engage_lvl;
    assign repeat_gap  = tick.now_ms - next_repeat_reg;

    assign neutral = (button_bits == '0) && (mag_x < release_lvl) && (mag_y < release_lvl)
                     && ({2'b00, tick.trigger_left} < release_lvl)
                     && ({2'b00, tick.trigger_right} < release_lvl);

    // trigger hysteresis
    always_comb
    begin
        trig_now[0] = {2'b00, tick.trigger_left}
                      >= (trig_pressed_reg[0] ? release_lvl : engage_lvl);
        trig_now[1] = {2'b00, tick.trigger_right}
                      >= (trig_pressed_reg[1] ? release_lvl : engage_lvl);
    end

    // direction pick, d-pad first
    always_comb
    begin
        priority if (bit_at(cur_bits, BTN_DPAD_UP))
            cur_dir = DIR_UP;
        else if (bit_at(cur_bits, BTN_DPAD_DOWN))
            cur_dir = DIR_DOWN;
        else if (bit_at(cur_bits, BTN_DPAD_LEFT))
            cur_dir = DIR_LEFT;
        else if (bit_at(cur_bits, BTN_DPAD_RIGHT))
            cur_dir = DIR_RIGHT;
        else if ((mag_x < dir_thr) && (mag_y < dir_thr))
            cur_dir = DIR_NONE;
        else if (mag_x > mag_y)
            cur_dir = tick.stick_x[15] ? DIR_LEFT : DIR_RIGHT;
        else
            cur_dir = tick.stick_y[15] ? DIR_UP : DIR_DOWN;
    end

    always_comb
    begin
        fire = '0;
        fire[POS_PREVPAGE]  = bit_at(cur_bits, BTN_LSHOULDER) & ~bit_at(old_bits, BTN_LSHOULDER);
        fire[POS_NEXTPAGE]  = bit_at(cur_bits, BTN_RSHOULDER) & ~bit_at(old_bits, BTN_RSHOULDER);
        fire[POS_MENU]      = bit_at(cur_bits, BTN_START) & ~bit_at(old_bits, BTN_START);
        fire[POS_HOME]      = bit_at(cur_bits, BTN_GUIDE) & ~bit_at(old_bits, BTN_GUIDE);
        fire[POS_LOCAL]     = bit_at(cur_bits, BTN_BACK) & ~bit_at(old_bits, BTN_BACK);
        fire[POS_BACK]      = bit_at(cur_bits, back_index_reg)
                              & ~bit_at(old_bits, back_index_reg);
        fire[POS_TOGGLE]    = bit_at(cur_bits, BTN_X) & ~bit_at(old_bits, BTN_X);
        fire[POS_SECONDARY] = bit_at(cur_bits, BTN_Y) & ~bit_at(old_bits, BTN_Y);
        fire[POS_CONFIRM]   = bit_at(cur_bits, confirm_index_reg)
                              & ~bit_at(old_bits, confirm_index_reg);
        fire[POS_PREVFACE]  = trig_now[0] & ~trig_pressed_reg[0];
        fire[POS_NEXTFACE]  = trig_now[1] & ~trig_pressed_reg[1];
        if (cur_dir != held_dir_reg)
            fire[POS_DIR] = (cur_dir != DIR_NONE);
        else
            fire[POS_DIR] = (cur_dir != DIR_NONE) && !repeat_gap[31];
    end

    always_comb
    begin
        prev_buttons_next = prev_buttons_reg;
        trig_pressed_next = trig_pressed_reg;
        held_dir_next     = held_dir_reg;
        next_repeat_next  = next_repeat_reg;
        gate_next         = gate_reg;
        was_attached_next = was_attached_reg;
        push              = 1'b0;
        if (tick_accept)
        begin
            was_attached_next = tick.attached;
            if (was_attached_reg && !tick.attached)
            begin
                gate_next         = 1'b1;
                held_dir_next     = DIR_NONE;
                prev_buttons_next = '0;
                trig_pressed_next = '0;
            end
            else if (tick.attached && enabled_reg && (!gate_reg || neutral))
            begin
                gate_next         = 1'b0;
                prev_buttons_next = button_bits;
                trig_pressed_next = trig_now;
                if (cur_dir != held_dir_reg)
                begin
                    held_dir_next    = cur_dir;
                    next_repeat_next = tick.now_ms + {16'h0000, repeat_delay_reg};
                end
                else if (fire[POS_DIR])
                    next_repeat_next = tick.now_ms + {16'h0000, repeat_interval_reg};
                push = (fire != '0);
            end
        end
        // enabled change arms the gate and drops held state
        if (cfg_write && (cfg_index == CFG_ENABLED) && (cfg_data[0] != enabled_reg))
        begin
            gate_next         = 1'b1;
            held_dir_next     = DIR_NONE;
            prev_buttons_next = '0;
            trig_pressed_next = '0;
        end
    end

    assign push_entry.fire = fire;
    assign push_entry.dir  = cur_dir[1:0];
    assign push_entry.gate = gate_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_engage_reg    <= RST_STICK_ENGAGE;
            stick_release_reg   <= RST_STICK_RELEASE;
            repeat_delay_reg    <= RST_REPEAT_DELAY;
            repeat_interval_reg <= RST_REPEAT_INTERVAL;
            back_index_reg      <= RST_BACK_INDEX;
            confirm_index_reg   <= RST_CONFIRM_INDEX;
            enabled_reg         <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_STICK_ENGAGE:    stick_engage_reg    <= cfg_data;
                CFG_STICK_RELEASE:   stick_release_reg   <= cfg_data;
                CFG_REPEAT_DELAY:    repeat_delay_reg    <= cfg_data;
                CFG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
                CFG_BACK_INDEX:      back_index_reg      <= cfg_data[4:0];
                CFG_CONFIRM_INDEX:   confirm_index_reg   <= cfg_data[4:0];
                CFG_ENABLED:         enabled_reg         <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_buttons_reg <= '0;
            trig_pressed_reg <= '0;
            held_dir_reg     <= DIR_NONE;
            next_repeat_reg  <= '0;
            gate_reg         <= 1'b1;
            was_attached_reg <= 1'b0;
        end
        else
        begin
            prev_buttons_reg <= prev_buttons_next;
            trig_pressed_reg <= trig_pressed_next;
            held_dir_reg     <= held_dir_next;
            next_repeat_reg  <= next_repeat_next;
            gate_reg         <= gate_next;
            was_attached_reg <= was_attached_next;
        end
    end

endmodule

### design/gaq_queue.sv
// short queue of classified ticks between front and back
`timescale 1ns / 1ps

module gaq_queue
    import gaq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t pop_entry
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

    entry_t        slots[QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/gaq_back.sv
// back end: walks each fire mask in order and emits one action a cycle while the output is not stalled
`timescale 1ns / 1ps

module gaq_back
    import gaq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  entry_t     q_entry,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] out_code,
    output logic       out_gate,
    output logic       out_last
);

    logic [FIRE_W-1:0]  mask_reg, mask_next;
    logic [1:0]         dir_reg;
    logic               gate_reg;
    logic               out_valid_reg, out_valid_next;
    logic [3:0]         code_reg;
    logic               last_reg;
    logic               out_gate_reg;
    logic               advance;
    logic               emit;
    logic [FIRE_W-1:0]  low_bit;
    logic [FIRE_W-1:0]  mask_after;
    logic [FIRE_PW-1:0] low_pos;

    assign advance    = !out_valid_reg || out_ready;
    assign emit       = advance && (mask_reg != '0);
    assign low_bit    = mask_reg & (~mask_reg + 1'b1);
    assign mask_after = emit ? (mask_reg & ~low_bit) : mask_reg;
    assign q_pop      = q_not_empty && (mask_after == '0);
    assign mask_next  = q_pop ? q_entry.fire : mask_after;

    always_comb
    begin
        low_pos = '0;
        for (int i = 0; i < FIRE_W; i++)
        begin
            if (low_bit[i])
                low_pos = low_pos | FIRE_PW'(i);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dir_reg  <= q_entry.dir;
            gate_reg <= q_entry.gate;
        end
        if (emit)
        begin
            code_reg     <= code_of(low_pos, dir_reg);
            last_reg     <= (mask_after == '0);
            out_gate_reg <= gate_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_code  = code_reg;
    assign out_gate  = out_gate_reg;
    assign out_last  = last_reg;

endmodule

### design/gamepad_action_qualifier.sv
// a tick accepted is written to the queue, loaded into the back end's mask, then its first action is registered
// one tick a cycle into the front while the queue is not full, one action a cycle out of the back while not stalled
// a tick with k actions, at most twelve, holds the back until all k are emitted; the queue absorbs bursts
// ticks are refused while the queue is full, behind a busy or stalled back end
// reset: registers return to their defaults, gate armed, queue and output empty
`timescale 1ns / 1ps

module gamepad_action_qualifier
    import gaq_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // button_bits, stick_x, stick_y, trigger_left, trigger_right, now_ms, zero fill
    input  logic [((BUTTON_COUNT+94+7)/8)*8-1:0] s_axis_tdata,
    // attached
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // action_code, zero fill
    output logic [7:0]             m_axis_tdata,
    // awaiting_neutral
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int OFS_SX  = BUTTON_COUNT;
    localparam int OFS_SY  = OFS_SX + 16;
    localparam int OFS_TL  = OFS_SY + 16;
    localparam int OFS_TR  = OFS_TL + 15;
    localparam int OFS_NOW = OFS_TR + 15;

    logic                    tick_accept;
    logic [BUTTON_COUNT-1:0] button_bits;
    tick_t                   tick;
    logic                    push;
    entry_t                  push_entry;
    logic                    q_full;
    logic                    q_pop;
    logic                    q_not_empty;
    entry_t                  q_entry;
    logic [3:0]              out_code;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;
    assign tick_accept   = s_axis_tvalid && s_axis_tready;

    assign button_bits        = s_axis_tdata[BUTTON_COUNT-1:0];
    assign tick.stick_x       = signed'(s_axis_tdata[OFS_SX +: 16]);
    assign tick.stick_y       = signed'(s_axis_tdata[OFS_SY +: 16]);
    assign tick.trigger_left  = s_axis_tdata[OFS_TL +: 15];
    assign tick.trigger_right = s_axis_tdata[OFS_TR +: 15];
    assign tick.now_ms        = s_axis_tdata[OFS_NOW +: 32];
    assign tick.attached      = s_axis_tuser;

    gaq_front #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick_accept (tick_accept),
        .button_bits (button_bits),
        .tick        (tick),
        .push        (push),
        .push_entry  (push_entry)
    );

    gaq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .pop_entry  (q_entry)
    );

    gaq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_code    (out_code),
        .out_gate    (m_axis_tuser),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, out_code};

endmodule

### design/gaq_checker.sv
// port-level checks on the action stream, bound to the top level
`timescale 1ns / 1ps

module gaq_checker
    import gaq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // a stalled request stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("action request dropped while stalled");

    // actions only come from ticks with the gate open
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tuser)
    else $error("action with neutral gate armed");

    // no unused action code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] != 4'd15) && (m_axis_tdata[7:4] == 4'd0))
    else $error("action code out of range");

    // a direction is always the final action of its tick
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[3:0] <= ACT_RIGHT) |-> m_axis_tlast)
    else $error("direction not last of tick");

endmodule

bind gamepad_action_qualifier gaq_checker u_gaq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/testbench.sv
// testbench for gamepad_action_qualifier: directed and random poll ticks against a predictor
`timescale 1ns / 1ps

module testbench;
    import gaq_pkg::*;

    localparam int NBTN = BUTTON_COUNT_DEF;
    localparam int TDATA_W = ((BUTTON_COUNT_DEF + 94 + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [NBTN-1:0] ALL_BUTTONS = {NBTN{1'b1}};

    typedef struct {
        logic [NBTN-1:0] buttons;
        logic [15:0]     stick_x;
        logic [15:0]     stick_y;
        logic [14:0]     trig_l;
        logic [14:0]     trig_r;
        logic            attached;
        logic [31:0]     now_ms;
    } poll_t;

    typedef struct packed {
        logic [3:0] code;
        logic       gate;
        logic       last;
    } action_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    gamepad_action_qualifier uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor copy of registers and held state
    logic [15:0]     engage_lvl = RST_STICK_ENGAGE;
    logic [15:0]     release_lvl = RST_STICK_RELEASE;
    logic [15:0]     delay_ms = RST_REPEAT_DELAY;
    logic [15:0]     interval_ms = RST_REPEAT_INTERVAL;
    logic [4:0]      back_idx = RST_BACK_INDEX;
    logic [4:0]      confirm_idx = RST_CONFIRM_INDEX;
    logic            enabled_q = 1'b1;
    logic [NBTN-1:0] prev_buttons = '0;
    logic [1:0]      trig_held = '0;
    logic [2:0]      held_dir = DIR_NONE;
    logic [31:0]     next_repeat = '0;
    logic            gate_armed = 1'b1;
    logic            was_attached = 1'b0;

    action_t pending_actions[$];
    action_t want;
    int      ticks_sent = 0;
    int      actions_seen = 0;
    int      cfg_writes = 0;
    int      fail_count = 0;
    logic    steady = 1'b0;
    logic [31:0] clock_ms = 32'd1000;
    poll_t   last_poll;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[gamepad_action_qualifier] ERROR");
        $finish;
    end

    always @(negedge clk)
    begin
        m_axis_tready = steady || ($urandom_range(0, 99) >= 36);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            actions_seen++;
            if (pending_actions.size() == 0)
            begin
                fail_count++;
                $display("%0t unexpected action: expected none, got tdata %0h gate %0b last %0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = pending_actions.pop_front();
                if (m_axis_tdata !== {4'd0, want.code} || m_axis_tuser !== want.gate ||
                    m_axis_tlast !== want.last)
                begin
                    fail_count++;
                    $display("%0t action mismatch: expected code %0d gate %0b last %0b,",
                             $time, want.code, want.gate, want.last,
                             " got tdata %0h gate %0b last %0b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    function automatic logic [15:0] axis_mag(input logic [15:0] v);
        return v[15] ? 16'(~v + 16'd1) : v;
    endfunction

    function automatic logic button_on(input logic [NBTN-1:0] b, input logic [4:0] idx);
        return (idx < NBTN) ? b[idx] : 1'b0;
    endfunction

    function automatic logic [NBTN-1:0] btn(input int idx);
        return NBTN'(1) << idx;
    endfunction

    function automatic void drop_held();
        gate_armed = 1'b1;
        held_dir = DIR_NONE;
        prev_buttons = '0;
        trig_held = '0;
    endfunction

    function automatic poll_t tick_of(input logic [NBTN-1:0] b, input int sx, input int sy,
                                      input int tl, input int tr, input logic att,
                                      input logic [31:0] now);
        poll_t p;
        p.buttons = b;
        p.stick_x = 16'(sx);
        p.stick_y = 16'(sy);
        p.trig_l = 15'(tl);
        p.trig_r = 15'(tr);
        p.attached = att;
        p.now_ms = now;
        return p;
    endfunction

    // expected actions of one accepted tick, in emission order
    task automatic qualify_tick(input poll_t p);
        logic [3:0]  codes[$];
        logic [4:0]  bind_bit[9];
        logic [3:0]  bind_act[9];
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] thr;
        logic [15:0] peak;
        logic [14:0] lvl;
        logic [2:0]  cur;
        logic        held;
        logic        pressed;
        logic [31:0] since;
        action_t     a;
        ax = axis_mag(p.stick_x);
        ay = axis_mag(p.stick_y);
        if (was_attached && !p.attached)
            drop_held();
        was_attached = p.attached;
        if (!p.attached || !enabled_q)
            return;
        if (gate_armed)
        begin
            if (p.buttons != '0 || ax >= release_lvl || ay >= release_lvl ||
                {1'b0, p.trig_l} >= release_lvl || {1'b0, p.trig_r} >= release_lvl)
                return;
            gate_armed = 1'b0;
        end
        bind_bit = '{BTN_LSHOULDER, BTN_RSHOULDER, BTN_START, BTN_GUIDE, BTN_BACK,
                     back_idx, BTN_X, BTN_Y, confirm_idx};
        bind_act = '{ACT_PREVPAGE, ACT_NEXTPAGE, ACT_MENU, ACT_HOME, ACT_LOCAL,
                     ACT_BACK, ACT_TOGGLE, ACT_SECONDARY, ACT_CONFIRM};
        for (int i = 0; i < 9; i++)
            if (button_on(p.buttons, bind_bit[i]) && !button_on(prev_buttons, bind_bit[i]))
                codes.push_back(bind_act[i]);
        for (int i = 0; i < 2; i++)
        begin
            lvl = (i == 0) ? p.trig_l : p.trig_r;
            held = trig_held[i];
            pressed = {1'b0, lvl} >= (held ? release_lvl : engage_lvl);
            if (pressed && !held)
                codes.push_back((i == 0) ? ACT_PREVFACE : ACT_NEXTFACE);
            trig_held[i] = pressed;
        end
        if (button_on(p.buttons, BTN_DPAD_UP))
            cur = DIR_UP;
        else if (button_on(p.buttons, BTN_DPAD_DOWN))
            cur = DIR_DOWN;
        else if (button_on(p.buttons, BTN_DPAD_LEFT))
            cur = DIR_LEFT;
        else if (button_on(p.buttons, BTN_DPAD_RIGHT))
            cur = DIR_RIGHT;
        else
        begin
            thr = (held_dir != DIR_NONE) ? release_lvl : engage_lvl;
            peak = (ax > ay) ? ax : ay;
            if (peak < thr)
                cur = DIR_NONE;
            else if (ax > ay)
                cur = p.stick_x[15] ? DIR_LEFT : DIR_RIGHT;
            else
                cur = p.stick_y[15] ? DIR_UP : DIR_DOWN;
        end
        // wrap-safe: repeat due once the difference is non-negative
        since = p.now_ms - next_repeat;
        if (cur != held_dir)
        begin
            held_dir = cur;
            if (cur != DIR_NONE)
                codes.push_back({1'b0, cur});
            next_repeat = p.now_ms + {16'd0, delay_ms};
        end
        else if (cur != DIR_NONE && !since[31])
        begin
            codes.push_back({1'b0, cur});
            next_repeat = p.now_ms + {16'd0, interval_ms};
        end
        prev_buttons = p.buttons;
        foreach (codes[i])
        begin
            a.code = codes[i];
            a.gate = gate_armed;
            a.last = (i == codes.size() - 1);
            pending_actions.push_back(a);
        end
    endtask

    task automatic send_poll(input poll_t p);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 36)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata = {{(TDATA_W - 115){1'b0}}, p.now_ms, p.trig_r, p.trig_l,
                        p.stick_y, p.stick_x, p.buttons};
        s_axis_tuser = p.attached;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        qualify_tick(p);
        ticks_sent++;
        last_poll = p;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_actions.size() != 0)
            @(posedge clk);
        // ticks with no actions may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        wait_drain();
        @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_STICK_ENGAGE:    engage_lvl = val;
            CFG_STICK_RELEASE:   release_lvl = val;
            CFG_REPEAT_DELAY:    delay_ms = val;
            CFG_REPEAT_INTERVAL: interval_ms = val;
            CFG_BACK_INDEX:      back_idx = val[4:0];
            CFG_CONFIRM_INDEX:   confirm_idx = val[4:0];
            CFG_ENABLED:
            begin
                if (val[0] != enabled_q)
                begin
                    enabled_q = val[0];
                    drop_held();
                end
            end
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] rand_axis();
        logic [15:0] m;
        case ($urandom_range(0, 5))
            0: m = 16'($urandom_range(0, 3000));
            1: m = release_lvl + 16'($urandom_range(0, 4)) - 16'd2;
            2: m = engage_lvl + 16'($urandom_range(0, 4)) - 16'd2;
            3: m = 16'h8000;
            default: return 16'($urandom());
        endcase
        if (m > 16'h8000)
            m = 16'h8000;
        if ($urandom_range(0, 1) != 0)
            return 16'(~m + 16'd1);
        return m[15] ? 16'h7FFF : m;
    endfunction

    function automatic logic [14:0] rand_trigger();
        logic [15:0] m;
        case ($urandom_range(0, 5))
            0: m = 16'd0;
            1: m = release_lvl + 16'($urandom_range(0, 4)) - 16'd2;
            2: m = engage_lvl + 16'($urandom_range(0, 4)) - 16'd2;
            3: m = 16'h7FFF;
            default: m = 16'($urandom());
        endcase
        return (m > 16'h7FFF) ? 15'h7FFF : m[14:0];
    endfunction

    function automatic logic [NBTN-1:0] rand_buttons(input logic [NBTN-1:0] held_now);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return btn($urandom_range(0, NBTN - 1));
            2: return held_now | btn($urandom_range(0, NBTN - 1));
            default: return NBTN'($urandom());
        endcase
    endfunction

    task automatic test_gate_and_bindings();
        send_poll(tick_of('0, 0, 0, 0, 0, 1'b0, 32'd100));
        send_poll(tick_of(ALL_BUTTONS, 0, 0, 0, 0, 1'b1, 32'd116));
        send_poll(tick_of('0, 8191, -8191, 8191, 8191, 1'b1, 32'd132));
        // every binding, both triggers and a d-pad direction at once
        send_poll(tick_of(ALL_BUTTONS, -32768, 32767, 32767, 32767, 1'b1, 32'hFFFF_FD00));
        send_poll(tick_of(ALL_BUTTONS, -32768, 32767, 32767, 32767, 1'b1, 32'hFFFF_FD0A));
        send_poll(tick_of(ALL_BUTTONS, -32768, 32767, 32767, 32767, 1'b1, 32'hFFFF_FE90));
        send_poll(tick_of(ALL_BUTTONS, -32768, 32767, 32767, 32767, 1'b1, 32'hFFFF_FF08));
        // repeat across the millisecond wrap
        send_poll(tick_of(ALL_BUTTONS, -32768, 32767, 32767, 32767, 1'b1, 32'h0000_0000));
        send_poll(tick_of(ALL_BUTTONS, -32768, 32767, 32767, 32767, 1'b1, 32'h0000_0010));
    endtask

    task automatic test_direction_hysteresis();
        send_poll(tick_of('0, -32768, 0, 0, 0, 1'b1, 32'h20));
        send_poll(tick_of('0, 32767, -32768, 0, 0, 1'b1, 32'h30));
        send_poll(tick_of('0, 0, 10000, 0, 0, 1'b1, 32'h40));
        send_poll(tick_of('0, 0, 0, 0, 0, 1'b1, 32'h50));
        send_poll(tick_of('0, 0, 10000, 0, 0, 1'b1, 32'h60));
        send_poll(tick_of('0, 20000, 20000, 0, 0, 1'b1, 32'h70));
        send_poll(tick_of(btn(BTN_DPAD_LEFT), 32767, 0, 0, 0, 1'b1, 32'h80));
    endtask

    task automatic test_trigger_hysteresis();
        send_poll(tick_of('0, 0, 0, 20000, 16384, 1'b1, 32'h90));
        send_poll(tick_of('0, 0, 0, 10000, 8192, 1'b1, 32'hA0));
        send_poll(tick_of('0, 0, 0, 5000, 8191, 1'b1, 32'hB0));
    endtask

    task automatic test_disconnect();
        send_poll(tick_of(btn(BTN_START), 0, 0, 20000, 0, 1'b0, 32'hC0));
        send_poll(tick_of(btn(RST_CONFIRM_INDEX), 0, 0, 0, 0, 1'b1, 32'hD0));
        send_poll(tick_of('0, 0, 0, 0, 0, 1'b1, 32'hE0));
        send_poll(tick_of(btn(RST_CONFIRM_INDEX), 0, 0, 0, 0, 1'b1, 32'hF0));
    endtask

    task automatic test_register_edges();
        write_reg(CFG_CONFIRM_INDEX, 16'd31);
        write_reg(CFG_BACK_INDEX, 16'd20);
        send_poll(tick_of('0, 0, 0, 0, 0, 1'b1, 32'h100));
        // confirm bound beyond the last button never fires
        send_poll(tick_of(btn(0) | btn(20), 0, 0, 0, 0, 1'b1, 32'h110));
        write_reg(CFG_SPARE, 16'hFFFF);
        write_reg(CFG_ENABLED, 16'd1);
        send_poll(tick_of('0, 0, 0, 0, 0, 1'b1, 32'h120));
        write_reg(CFG_ENABLED, 16'd0);
        send_poll(tick_of(btn(20), 0, 0, 0, 0, 1'b1, 32'h130));
        write_reg(CFG_ENABLED, 16'd1);
        send_poll(tick_of(btn(20), 0, 0, 0, 0, 1'b1, 32'h140));
        send_poll(tick_of('0, 0, 0, 0, 0, 1'b1, 32'h150));
        send_poll(tick_of(btn(20), 0, 0, 0, 0, 1'b1, 32'h160));
    endtask

    task automatic random_phase(input int count, input logic [15:0] eng, input logic [15:0] rel,
                                input logic [15:0] dly, input logic [15:0] ivl,
                                input logic [4:0] bk, input logic [4:0] cf, input bit pause_mid);
        poll_t p;
        int    roll;
        write_reg(CFG_STICK_ENGAGE, eng);
        write_reg(CFG_STICK_RELEASE, rel);
        write_reg(CFG_REPEAT_DELAY, dly);
        write_reg(CFG_REPEAT_INTERVAL, ivl);
        write_reg(CFG_BACK_INDEX, {11'd0, bk});
        write_reg(CFG_CONFIRM_INDEX, {11'd0, cf});
        for (int n = 0; n < count; n++)
        begin
            if (pause_mid && n == count / 2)
                wait_drain();
            p = last_poll;
            roll = $urandom_range(0, 99);
            if (roll < 15)
                p = tick_of('0, 0, 0, 0, 0, 1'b1, 32'd0);
            else if (roll < 45)
                p.attached = 1'b1;
            else
            begin
                p.buttons = rand_buttons(p.buttons);
                p.stick_x = rand_axis();
                p.stick_y = rand_axis();
                p.trig_l = rand_trigger();
                p.trig_r = rand_trigger();
                p.attached = ($urandom_range(0, 19) != 0);
            end
            clock_ms += 32'($urandom_range(0, 40));
            if ($urandom_range(0, 49) == 0)
                clock_ms = $urandom();
            p.now_ms = clock_ms;
            send_poll(p);
        end
    endtask

    task automatic test_random();
        steady = 1'b1;
        random_phase(40, 16'd32768, 16'd32768, 16'd0, 16'd0, 5'd20, 5'd14, 1'b0);
        steady = 1'b0;
        random_phase(45, RST_STICK_ENGAGE, RST_STICK_RELEASE, 16'd60, 16'd25,
                     RST_BACK_INDEX, RST_CONFIRM_INDEX, 1'b0);
        random_phase(35, 16'd0, 16'd2000, 16'hFFFF, 16'hFFFF, 5'd31, 5'd20, 1'b0);
        random_phase(20, 16'd12000, 16'd0, 16'd30, 16'd0, 5'd4, 5'd9, 1'b0);
        write_reg(CFG_ENABLED, 16'd0);
        random_phase(10, RST_STICK_ENGAGE, RST_STICK_RELEASE, 16'd60, 16'd25,
                     RST_BACK_INDEX, RST_CONFIRM_INDEX, 1'b0);
        write_reg(CFG_ENABLED, 16'd1);
        random_phase(50, 16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                     16'($urandom_range(0, 200)), 16'($urandom_range(0, 100)),
                     5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 1'b1);
    endtask

    initial
    begin
        last_poll = tick_of('0, 0, 0, 0, 0, 1'b1, 32'd0);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_gate_and_bindings();
        test_direction_hysteresis();
        test_trigger_hysteresis();
        test_disconnect();
        test_register_edges();
        test_random();
        wait_drain();
        $display("%0d ticks sent, %0d actions checked, %0d register writes",
                 ticks_sent, actions_seen, cfg_writes);
        $display("covered gate, disconnect, button and trigger edges, direction repeat and wrap");
        if (fail_count == 0)
            $display("[gamepad_action_qualifier] OK");
        else
            $display("[gamepad_action_qualifier] ERROR");
        $finish;
    end

endmodule
